FILE: sv/fgn_pkg.sv
// Shared constants and codes for the fractal gradient noise unit.
`default_nettype none

package fgn_pkg;

  // Lattice table size; cell and hash indexes wrap to its low bits.
  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);

  localparam int PERM_W = 8;
  localparam int GRAD_W = 32;

  // Transaction kinds on the input channel.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_PERM   = 2'd1;
  localparam logic [1:0] KIND_GRAD   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OCTAVES = 2'd0;
  localparam logic [1:0] CFG_FREQ    = 2'd1;
  localparam logic [1:0] CFG_GAIN    = 2'd2;

  localparam logic [4:0]  OCTAVES_RST = 5'd8;
  localparam logic [15:0] FREQ_RST    = 16'd8192;
  localparam logic [15:0] GAIN_RST    = 16'd16384;

  localparam logic [15:0] WEIGHT_ONE  = 16'd32768;

  localparam int NOISE_W = 20;
  localparam int ACC_W   = 28;

  // Per-octave token flags that travel with the data.
  typedef struct packed {
    logic first;
    logic last;
    logic empty;
  } tok_t;

endpackage

`default_nettype wire

FILE: sv/fgn_ram.sv
// Generic RAM: one write port, two registered read ports with enable.
`default_nettype none

module fgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic      [WIDTH-1:0]         rd_data0,
  output logic      [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd0_r;
  logic [WIDTH-1:0] rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_r <= mem_r[rd_addr0];
      rd1_r <= mem_r[rd_addr1];
    end
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;

endmodule

`default_nettype wire

FILE: sv/fractal_gradient_noise_2d_unit.sv
// Top level of the fractal 2-D gradient noise unit: octave issue and noise pipeline.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | kind, coord_x, coord_y, table_index, values
//  out_    | output    | out_valid/out_stall| noise_value
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// A sample issues max(1, octave_count) octaves; the issue stage sends one octave per
// cycle while out_stall does not hold it, into a twelve-stage pipeline, and the
// result is valid once the sample's last octave has passed through it.
// Table loads are taken only when no octave is in flight and write all table copies.
// Reset is synchronous and clears control state and the configuration registers.
// out_stall while a result is held freezes the whole pipeline, including input acceptance.
`default_nettype none

module fractal_gradient_noise_2d_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_kind,
  input  wire logic signed [31:0]           in_coord_x,
  input  wire logic signed [31:0]           in_coord_y,
  input  wire logic [7:0]                   in_table_index,
  input  wire logic [7:0]                   in_perm_value,
  input  wire logic signed [15:0]           in_grad_x,
  input  wire logic signed [15:0]           in_grad_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [fgn_pkg::NOISE_W-1:0] out_noise_value,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_wdata
);

  import fgn_pkg::*;

  // Configuration.
  logic [4:0]  octaves_r;
  logic [15:0] freq_r;
  logic [15:0] gain_r;

  // Handshake and control.
  logic adv;
  logic busy;
  logic acc_sample;
  logic acc_load;
  logic wr_perm;
  logic wr_grad;

  // Issue stage.
  logic               p0_valid_r;
  logic signed [31:0] p0_x_r;
  logic signed [31:0] p0_y_r;
  logic [15:0]        p0_w_r;
  logic [4:0]         p0_left_r;
  logic               p0_first_r;
  logic               p0_empty_r;
  logic signed [48:0] scale_x;
  logic signed [48:0] scale_y;
  logic [31:0]        wprod;
  logic [16:0]        wq;
  logic [15:0]        w_next;
  logic [TBL_AW-1:0]  x0;
  logic [TBL_AW-1:0]  x1;
  tok_t               p0_tok;

  // Stage 1.
  logic               v1_r;
  tok_t               t1_r;
  logic [15:0]        fx1_r, fy1_r, w1_r;
  logic [TBL_AW-1:0]  y0_1_r, y1_1_r;
  logic [PERM_W-1:0]  px0, px1;
  logic [TBL_AW-1:0]  a00, a10, a01, a11;

  // Stage 2.
  logic               v2_r;
  tok_t               t2_r;
  logic [15:0]        fx2_r, fy2_r, w2_r;
  logic [31:0]        fxx2_r, fyy2_r;
  logic [PERM_W-1:0]  b00, b10, b01, b11;
  logic [17:0]        tx, ty;
  logic [49:0]        smx, smy;

  // Stage 3.
  logic               v3_r;
  tok_t               t3_r;
  logic [15:0]        fx3_r, fy3_r, w3_r, sx3_r, sy3_r;
  logic [PERM_W-1:0]  h00, h10, h01, h11;

  // Stage 4.
  logic               v4_r;
  tok_t               t4_r;
  logic [15:0]        fx4_r, fy4_r, w4_r, sx4_r, sy4_r;
  logic [GRAD_W-1:0]  g00, g10, g01, g11;
  logic signed [17:0] dx0, dx1, dy0, dy1;

  // Stage 5.
  logic               v5_r;
  tok_t               t5_r;
  logic [15:0]        w5_r, sx5_r, sy5_r;
  logic signed [33:0] p00x_r, p00y_r, p10x_r, p10y_r;
  logic signed [33:0] p01x_r, p01y_r, p11x_r, p11y_r;
  logic signed [34:0] s00, s10, s01, s11;

  // Stage 6.
  logic               v6_r;
  tok_t               t6_r;
  logic [15:0]        w6_r, sx6_r, sy6_r;
  logic signed [19:0] d00_r, d10_r, d01_r, d11_r;
  logic signed [20:0] diff0, diff1;

  // Stage 7.
  logic               v7_r;
  tok_t               t7_r;
  logic [15:0]        w7_r, sy7_r;
  logic signed [19:0] d00_7_r, d01_7_r;
  logic signed [37:0] m0_r, m1_r;
  logic signed [21:0] la, lb;

  // Stage 8.
  logic               v8_r;
  tok_t               t8_r;
  logic [15:0]        w8_r, sy8_r;
  logic signed [19:0] a8_r, b8_r;
  logic signed [20:0] diff2;

  // Stage 9.
  logic               v9_r;
  tok_t               t9_r;
  logic [15:0]        w9_r;
  logic signed [19:0] a9_r;
  logic signed [37:0] m2_r;
  logic signed [21:0] lv;

  // Stage 10.
  logic               v10_r;
  tok_t               t10_r;
  logic [15:0]        w10_r;
  logic signed [19:0] v10_r_val;

  // Stage 11.
  logic               v11_r;
  tok_t               t11_r;
  logic signed [36:0] vw11_r;
  logic signed [ACC_W-1:0] contrib;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_r;

  // Output register.
  logic                      out_valid_r;
  logic signed [NOISE_W-1:0] out_noise_r;
  logic signed [NOISE_W-1:0] sat_val;

  // ---------------------------------------------------------------- control
  assign adv       = !out_valid_r || !out_stall;
  assign busy      = p0_valid_r | v1_r | v2_r | v3_r | v4_r | v5_r | v6_r |
                     v7_r | v8_r | v9_r | v10_r | v11_r;
  // A load writes the tables at once, so it waits until no octave is in flight.
  assign in_stall  = !adv || (p0_valid_r && (p0_left_r != 5'd0)) ||
                     (((in_kind == KIND_PERM) || (in_kind == KIND_GRAD)) && busy);
  assign acc_sample = in_valid && !in_stall && (in_kind == KIND_SAMPLE);
  assign acc_load   = in_valid && !in_stall;
  assign wr_perm    = acc_load && (in_kind == KIND_PERM);
  assign wr_grad    = acc_load && (in_kind == KIND_GRAD);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octaves_r <= OCTAVES_RST;
      freq_r    <= FREQ_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OCTAVES: octaves_r <= cfg_wdata[4:0];
        CFG_FREQ:    freq_r    <= cfg_wdata;
        CFG_GAIN:    gain_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------- issue
  assign scale_x = p0_x_r * $signed({1'b0, freq_r});
  assign scale_y = p0_y_r * $signed({1'b0, freq_r});
  assign wprod   = 32'(p0_w_r) * 32'(gain_r);
  assign wq      = wprod[31:15];
  assign w_next  = wq[16] ? 16'hFFFF : wq[15:0];
  assign x0      = p0_x_r[16 +: TBL_AW];
  assign x1      = x0 + TBL_AW'(1);
  assign p0_tok  = '{first: p0_first_r, last: (p0_left_r == 5'd0), empty: p0_empty_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (adv) begin
      if (p0_valid_r && (p0_left_r != 5'd0)) begin
        p0_valid_r <= 1'b1;
      end else begin
        p0_valid_r <= acc_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p0_valid_r && (p0_left_r != 5'd0)) begin
        p0_x_r     <= scale_x[43:12];
        p0_y_r     <= scale_y[43:12];
        p0_w_r     <= w_next;
        p0_left_r  <= p0_left_r - 5'd1;
        p0_first_r <= 1'b0;
      end else if (acc_sample) begin
        p0_x_r     <= in_coord_x;
        p0_y_r     <= in_coord_y;
        p0_w_r     <= WEIGHT_ONE;
        p0_first_r <= 1'b1;
        p0_empty_r <= (octaves_r == 5'd0);
        p0_left_r  <= (octaves_r == 5'd0) ? 5'd0 : octaves_r - 5'd1;
      end
    end
  end

  // ---------------------------------------------------------------- tables
  // Each lookup level has its own copies so all its corners are read in the same cycle.
  fgn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a (
    .clk(clk), .wr_en(wr_perm), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data(in_perm_value), .rd_en(adv), .rd_addr0(x0), .rd_addr1(x1),
    .rd_data0(px0), .rd_data1(px1)
  );

  assign a00 = TBL_AW'(px0) + y0_1_r;
  assign a10 = TBL_AW'(px1) + y0_1_r;
  assign a01 = TBL_AW'(px0) + y1_1_r;
  assign a11 = TBL_AW'(px1) + y1_1_r;

  fgn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b (
    .clk(clk), .wr_en(wr_perm), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data(in_perm_value), .rd_en(adv), .rd_addr0(a00), .rd_addr1(a10),
    .rd_data0(b00), .rd_data1(b10)
  );

  fgn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_c (
    .clk(clk), .wr_en(wr_perm), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data(in_perm_value), .rd_en(adv), .rd_addr0(a01), .rd_addr1(a11),
    .rd_data0(b01), .rd_data1(b11)
  );

  fgn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_d (
    .clk(clk), .wr_en(wr_perm), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data(in_perm_value), .rd_en(adv), .rd_addr0(TBL_AW'(b00)),
    .rd_addr1(TBL_AW'(b10)), .rd_data0(h00), .rd_data1(h10)
  );

  fgn_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_e (
    .clk(clk), .wr_en(wr_perm), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data(in_perm_value), .rd_en(adv), .rd_addr0(TBL_AW'(b01)),
    .rd_addr1(TBL_AW'(b11)), .rd_data0(h01), .rd_data1(h11)
  );

  fgn_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_grad_a (
    .clk(clk), .wr_en(wr_grad), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data({in_grad_x, in_grad_y}), .rd_en(adv), .rd_addr0(TBL_AW'(h00)),
    .rd_addr1(TBL_AW'(h10)), .rd_data0(g00), .rd_data1(g10)
  );

  fgn_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_grad_b (
    .clk(clk), .wr_en(wr_grad), .wr_addr(in_table_index[TBL_AW-1:0]),
    .wr_data({in_grad_x, in_grad_y}), .rd_en(adv), .rd_addr0(TBL_AW'(h01)),
    .rd_addr1(TBL_AW'(h11)), .rd_data0(g01), .rd_data1(g11)
  );

  // ---------------------------------------------------------------- datapath
  assign tx  = 18'd196608 - {1'b0, fx2_r, 1'b0};
  assign ty  = 18'd196608 - {1'b0, fy2_r, 1'b0};
  assign smx = 50'(fxx2_r) * 50'(tx);
  assign smy = 50'(fyy2_r) * 50'(ty);

  assign dx0 = $signed({2'b00, fx4_r});
  assign dx1 = dx0 - 18'sd65536;
  assign dy0 = $signed({2'b00, fy4_r});
  assign dy1 = dy0 - 18'sd65536;

  assign s00 = 35'(p00x_r) + 35'(p00y_r);
  assign s10 = 35'(p10x_r) + 35'(p10y_r);
  assign s01 = 35'(p01x_r) + 35'(p01y_r);
  assign s11 = 35'(p11x_r) + 35'(p11y_r);

  assign diff0 = 21'(d10_r) - 21'(d00_r);
  assign diff1 = 21'(d11_r) - 21'(d01_r);

  assign la = 22'(d00_7_r) + m0_r[37:16];
  assign lb = 22'(d01_7_r) + m1_r[37:16];

  assign diff2 = 21'(b8_r) - 21'(a8_r);
  assign lv    = 22'(a9_r) + m2_r[37:16];

  assign contrib = t11_r.empty ? '0 : ACC_W'($signed(vw11_r[36:15]));
  assign acc_sum = (t11_r.first ? '0 : acc_r) + contrib;
  assign sat_val = (acc_sum > ACC_W'(524287))  ? NOISE_W'(524287) :
                   (acc_sum < -ACC_W'(524288)) ? NOISE_W'(-524288) :
                   acc_sum[NOISE_W-1:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v9_r <= 1'b0; v10_r <= 1'b0; v11_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= p0_valid_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      out_valid_r <= v11_r && t11_r.last;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= p0_tok;
      fx1_r  <= p0_x_r[15:0];
      fy1_r  <= p0_y_r[15:0];
      w1_r   <= p0_w_r;
      y0_1_r <= p0_y_r[16 +: TBL_AW];
      y1_1_r <= p0_y_r[16 +: TBL_AW] + TBL_AW'(1);

      t2_r   <= t1_r;
      fx2_r  <= fx1_r;
      fy2_r  <= fy1_r;
      w2_r   <= w1_r;
      fxx2_r <= 32'(fx1_r) * 32'(fx1_r);
      fyy2_r <= 32'(fy1_r) * 32'(fy1_r);

      t3_r  <= t2_r;
      fx3_r <= fx2_r;
      fy3_r <= fy2_r;
      w3_r  <= w2_r;
      sx3_r <= smx[47:32];
      sy3_r <= smy[47:32];

      t4_r  <= t3_r;
      fx4_r <= fx3_r;
      fy4_r <= fy3_r;
      w4_r  <= w3_r;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;

      t5_r   <= t4_r;
      w5_r   <= w4_r;
      sx5_r  <= sx4_r;
      sy5_r  <= sy4_r;
      p00x_r <= $signed(g00[31:16]) * dx0;
      p00y_r <= $signed(g00[15:0])  * dy0;
      p10x_r <= $signed(g10[31:16]) * dx1;
      p10y_r <= $signed(g10[15:0])  * dy0;
      p01x_r <= $signed(g01[31:16]) * dx0;
      p01y_r <= $signed(g01[15:0])  * dy1;
      p11x_r <= $signed(g11[31:16]) * dx1;
      p11y_r <= $signed(g11[15:0])  * dy1;

      t6_r  <= t5_r;
      w6_r  <= w5_r;
      sx6_r <= sx5_r;
      sy6_r <= sy5_r;
      d00_r <= s00[34:15];
      d10_r <= s10[34:15];
      d01_r <= s01[34:15];
      d11_r <= s11[34:15];

      t7_r    <= t6_r;
      w7_r    <= w6_r;
      sy7_r   <= sy6_r;
      d00_7_r <= d00_r;
      d01_7_r <= d01_r;
      m0_r    <= 38'(diff0) * 38'($signed({1'b0, sx6_r}));
      m1_r    <= 38'(diff1) * 38'($signed({1'b0, sx6_r}));

      t8_r  <= t7_r;
      w8_r  <= w7_r;
      sy8_r <= sy7_r;
      a8_r  <= la[19:0];
      b8_r  <= lb[19:0];

      t9_r <= t8_r;
      w9_r <= w8_r;
      a9_r <= a8_r;
      m2_r <= 38'(diff2) * 38'($signed({1'b0, sy8_r}));

      t10_r     <= t9_r;
      w10_r     <= w9_r;
      v10_r_val <= lv[19:0];

      t11_r  <= t10_r;
      vw11_r <= 37'(v10_r_val) * 37'($signed({1'b0, w10_r}));

      if (v11_r) begin
        acc_r <= acc_sum;
      end
      if (v11_r && t11_r.last) begin
        out_noise_r <= sat_val;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

`default_nettype wire

FILE: sv/fgn_checker.sv
// Port-level checker for the fractal gradient noise unit, with its bind.
`default_nettype none

module fgn_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [1:0]                    in_kind,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [fgn_pkg::NOISE_W-1:0] out_noise_value,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  import fgn_pkg::*;

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("result changed while stalled");

  // A stalled result freezes the pipeline, so nothing enters.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output stalled");

  // A table load is taken only with no octave in flight, so out_valid does not rise right after it.
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_PERM || in_kind == KIND_GRAD)
    |=> !$rose(out_valid))
    else $error("result appeared right after a table load");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind fractal_gradient_noise_2d_unit fgn_checker u_fgn_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_kind(in_kind), .out_valid(out_valid), .out_stall(out_stall),
  .out_noise_value(out_noise_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

`default_nettype wire

FILE: tb/fractal_gradient_noise_2d_checker.sv
// Checker for the fractal gradient noise unit: predicts each sample and compares results.
`default_nettype none

module fractal_gradient_noise_2d_checker
  import fgn_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [1:0]                in_kind,
  input  wire logic signed [31:0]        in_coord_x,
  input  wire logic signed [31:0]        in_coord_y,
  input  wire logic [7:0]                in_table_index,
  input  wire logic [7:0]                in_perm_value,
  input  wire logic signed [15:0]        in_grad_x,
  input  wire logic signed [15:0]        in_grad_y,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic signed [NOISE_W-1:0] out_noise_value,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [15:0]               cfg_wdata,
  output int                             fail_count,
  output int                             noise_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [4:0]  octaves;
  logic [15:0] freq;
  logic [15:0] gain;
  logic [7:0]  perm_mem [TABLE_SIZE];
  logic [31:0] grad_mem [TABLE_SIZE];
  logic signed [NOISE_W-1:0] noise_queue [$];

  function automatic longint smoothstep(longint f);
    longint t;
    t = (longint'(3) <<< 16) - 2 * f;
    return (f * f * t) >>> 32;
  endfunction

  function automatic longint lerp(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic longint grad_dot(logic [7:0] xi, logic [7:0] yi, longint dx, longint dy);
    logic [7:0] h;
    logic [31:0] g;
    longint gx, gy;
    h = perm_mem[perm_mem[8'(perm_mem[xi] + yi)]];
    g = grad_mem[h];
    gx = longint'($signed(g[31:16]));
    gy = longint'($signed(g[15:0]));
    return (gx * dx + gy * dy) >>> 15;
  endfunction

  function automatic longint octave_noise(longint x, longint y);
    longint ix, iy, fx, fy, sx, sy, d00, d10, d01, d11;
    logic [7:0] x0, y0;
    ix = x >>> 16;
    iy = y >>> 16;
    fx = x - ix * 65536;
    fy = y - iy * 65536;
    x0 = ix[7:0];
    y0 = iy[7:0];
    sx = smoothstep(fx);
    sy = smoothstep(fy);
    d00 = grad_dot(x0, y0, fx, fy);
    d10 = grad_dot(x0 + 8'd1, y0, fx - 65536, fy);
    d01 = grad_dot(x0, y0 + 8'd1, fx, fy - 65536);
    d11 = grad_dot(x0 + 8'd1, y0 + 8'd1, fx - 65536, fy - 65536);
    return lerp(lerp(d00, d10, sx), lerp(d01, d11, sx), sy);
  endfunction

  function automatic logic signed [NOISE_W-1:0] fractal_noise(logic signed [31:0] cx,
                                                              logic signed [31:0] cy);
    longint x, y, w, sum, v;
    x = cx;
    y = cy;
    w = 32768;
    sum = 0;
    for (int i = 0; i < octaves; i++) begin
      sum += (octave_noise(x, y) * w) >>> 15;
      v = (x * longint'(freq)) >>> 12;
      x = longint'($signed(v[31:0]));
      v = (y * longint'(freq)) >>> 12;
      y = longint'($signed(v[31:0]));
      w = (w * longint'(gain)) >>> 15;
      if (w > 65535) w = 65535;
    end
    if (sum > 524287) sum = 524287;
    if (sum < -524288) sum = -524288;
    return sum[NOISE_W-1:0];
  endfunction

  assign noise_pending = noise_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      octaves <= OCTAVES_RST;
      freq <= FREQ_RST;
      gain <= GAIN_RST;
      fail_count <= 0;
      noise_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OCTAVES: octaves <= cfg_wdata[4:0];
          CFG_FREQ: freq <= cfg_wdata;
          CFG_GAIN: gain <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_kind)
          KIND_SAMPLE: noise_queue.push_back(fractal_noise(in_coord_x, in_coord_y));
          KIND_PERM: perm_mem[in_table_index] = in_perm_value;
          KIND_GRAD: grad_mem[in_table_index] = {in_grad_x, in_grad_y};
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (noise_queue.size() == 0) begin
          $error("unexpected result transaction: noise_value actual %0d", out_noise_value);
          fail_count <= fail_count + 1;
        end else begin
          logic signed [NOISE_W-1:0] want;
          want = noise_queue.pop_front();
          if (want !== out_noise_value) begin
            $error("noise_value mismatch: expected %0d, actual %0d", want, out_noise_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

FILE: tb/fractal_gradient_noise_2d_unit_test.sv
// Testbench top for the fractal gradient noise unit: stimulus, idling and verdict.
`default_nettype none

module fractal_gradient_noise_2d_unit_test;
  import fgn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_SAMPLE;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic [7:0] in_table_index = '0;
  logic [7:0] in_perm_value = '0;
  logic signed [15:0] in_grad_x = '0;
  logic signed [15:0] in_grad_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NOISE_W-1:0] out_noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_OCTAVES;
  logic [15:0] cfg_wdata = '0;
  int fail_count;
  int noise_pending;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 2000000;

  fractal_gradient_noise_2d_unit uut (.*);
  fractal_gradient_noise_2d_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 8);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic send(logic [1:0] kind, logic [31:0] x, logic [31:0] y, logic [7:0] idx,
                      logic [7:0] pv, logic [15:0] gx, logic [15:0] gy);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_coord_x <= x;
    in_coord_y <= y;
    in_table_index <= idx;
    in_perm_value <= pv;
    in_grad_x <= gx;
    in_grad_y <= gy;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic sample(logic [31:0] x, logic [31:0] y);
    send(KIND_SAMPLE, x, y, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (noise_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
    endcase
  endfunction

  initial begin
    logic [15:0] phase_cfg [6][3];
    phase_cfg = '{'{16'd8, 16'd8192, 16'd16384}, '{16'd1, 16'd0, 16'd0},
                  '{16'd16, 16'd65535, 16'd32768}, '{16'd0, 16'd4096, 16'd65535},
                  '{16'd31, 16'd12345, 16'd20000}, '{16'd3, 16'd8192, 16'd30000}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every table entry is written before any sample reads it.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      send(KIND_PERM, $urandom, $urandom, 8'(i), 8'($urandom), 16'($urandom),
           16'($urandom));
      send(KIND_GRAD, $urandom, $urandom, 8'(i), 8'($urandom), 16'($urandom),
           16'($urandom));
    end
    send(KIND_PERM, 32'd0, 32'd0, 8'd0, 8'd255, 16'd0, 16'd0);
    send(KIND_PERM, 32'd0, 32'd0, 8'd255, 8'd0, 16'd0, 16'd0);
    send(KIND_GRAD, 32'd0, 32'd0, 8'd0, 8'd0, 16'h8000, 16'h8000);
    send(KIND_GRAD, 32'd0, 32'd0, 8'd255, 8'd0, 16'h7fff, 16'h7fff);
    send(KIND_GRAD, 32'd0, 32'd0, 8'd1, 8'd0, 16'h7fff, 16'h8000);

    // Directed samples with the reset configuration.
    sample(32'h0, 32'h0);
    sample(32'h7fff_ffff, 32'h7fff_ffff);
    sample(32'h8000_0000, 32'h8000_0000);
    sample(32'h7fff_ffff, 32'h8000_0000);
    sample(32'h0001_0000, 32'hffff_0000);
    sample(32'h0000_ffff, 32'hffff_ffff);
    sample(32'h0000_8000, 32'h00ff_8000);
    sample(32'hffff_ffff, 32'h0000_0001);
    send(2'd3, $urandom, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
         16'($urandom));

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_OCTAVES, phase_cfg[p][0]);
      write_reg(CFG_FREQ, phase_cfg[p][1]);
      write_reg(CFG_GAIN, phase_cfg[p][2]);
      if (p == 1) write_reg(2'd3, 16'hffff);
      if (p == 5) quiet = 1'b1;
      sample(32'h7fff_ffff, 32'h8000_0000);
      for (int n = 0; n < 65; n++) begin
        case ($urandom_range(0, 19))
          0: send(KIND_PERM, $urandom, $urandom, 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
          1: send(KIND_GRAD, $urandom, $urandom, 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
          2: begin
            send(2'd3, $urandom, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom));
            n--;
          end
          default: sample(rand_coord(), rand_coord());
        endcase
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (noise_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
